// ----- design/allocation_event_log_checker_core_assert.svh -----
// Assertion macros for the allocation event log checker core
`ifndef ALLOCATION_EVENT_LOG_CHECKER_CORE_ASSERT_SVH
`define ALLOCATION_EVENT_LOG_CHECKER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define AELC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AELC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AELC_ASSERT_IMPL(label, ante, cons, msg)
`define AELC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- design/aelc_pkg.sv -----
// Package: command, status and transfer types of the allocation event log checker
`timescale 1ns / 1ps
`default_nettype none
package aelc_pkg;

    localparam int ADDR_W = 32;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_LEAK  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_STATIC  = 2'd0,
        ST_DYNAMIC = 2'd1,
        ST_FREED   = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] address;
    } t_item;

    typedef struct packed {
        logic              ok;
        t_status           status;
        logic [ADDR_W-1:0] leak_address;
    } t_result;

endpackage
`default_nettype wire

// ----- design/allocation_event_log_checker_core.sv -----
// Top level: allocation event log with query and leak check sequencer
// An append gives its result in the cycle after start; a query scans from newest
//   to oldest entry, a leak check tests each unfreed entry against later entries.
// One command at a time: busy holds off start until the result strobe; the
//   receiver cannot stall, so a result never waits and a scan never pauses.
// Reset (synchronous, active low) empties the log; entry contents stay as
//   they were and are never read before they are written again.
`timescale 1ns / 1ps
`default_nettype none
module allocation_event_log_checker_core #(
    parameter int LOG_DEPTH = 64,
    parameter int ADDR_BITS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire aelc_pkg::t_item i_item,
    output logic                busy,
    output logic                o_valid,
    output aelc_pkg::t_result   o_result
);
    import aelc_pkg::*;
    `include "allocation_event_log_checker_core_assert.svh"

    // stored address width: an input address never carries more than ADDR_W bits
    localparam int SW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int IW = $clog2(LOG_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_QSCAN   = 5'b00010,
        S_LOUT_RD = 5'b00100,
        S_LOUT_CK = 5'b01000,
        S_LIN     = 5'b10000
    } t_state;

    // entry = {freed mark, address}
    logic [SW:0]   mem [LOG_DEPTH];
    logic [SW:0]   r_rd_a;
    logic [SW:0]   r_rd_b;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;           // query index / leak outer index
    logic [CW-1:0] r_j, n_j;           // leak inner index
    logic          r_dv, n_dv;         // read data of the scan is valid
    logic          r_end, n_end;       // last scan read has been issued
    logic [SW-1:0] r_qaddr;
    logic          r_valid, n_valid;
    t_result       r_res, n_res;

    logic          accept;
    logic          full;
    logic          wr_en;
    logic [SW:0]   wr_data;
    logic [SW-1:0] in_addr;
    logic [SW-1:0] cmp_a;
    logic [SW-1:0] cmp_b;
    logic          cmp_eq;
    logic          q_hit;
    logic          l_hit;

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    assign accept  = start && !busy;
    assign full    = (r_count == CW'(LOG_DEPTH));
    assign in_addr = i_item.address[SW-1:0];
    assign wr_data = {(i_item.cmd == CMD_FREE), in_addr};

    // the single compare unit: port A against the query key, or port B against port A
    assign cmp_a  = (r_state == S_QSCAN) ? r_rd_a[SW-1:0] : r_rd_b[SW-1:0];
    assign cmp_b  = (r_state == S_QSCAN) ? r_qaddr : r_rd_a[SW-1:0];
    assign cmp_eq = (cmp_a == cmp_b);
    assign q_hit  = r_dv && cmp_eq;
    assign l_hit  = r_dv && r_rd_b[SW] && cmp_eq;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i     = r_i;
        n_j     = r_j;
        n_dv    = r_dv;
        n_end   = r_end;
        n_valid = 1'b0;
        n_res   = r_res;
        wr_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_item.cmd)
                        CMD_ALLOC, CMD_FREE: begin
                            // append unless the log is full
                            n_valid = 1'b1;
                            n_res   = '{ok: !full, status: ST_STATIC, leak_address: '0};
                            if (!full) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_QUERY: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                                n_res   = '{ok: 1'b1, status: ST_STATIC, leak_address: '0};
                            end else begin
                                n_i     = r_count - CW'(1);
                                n_dv    = 1'b0;
                                n_end   = 1'b0;
                                n_state = S_QSCAN;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                                n_res   = '{ok: 1'b1, status: ST_STATIC, leak_address: '0};
                            end else begin
                                n_i     = '0;
                                n_state = S_LOUT_RD;
                            end
                        end
                    endcase
                end
            end
            S_QSCAN: begin
                // newest to oldest, one read issued per cycle
                if (q_hit) begin
                    n_valid = 1'b1;
                    n_res   = '{ok: 1'b1,
                                status: (r_rd_a[SW] ? ST_FREED : ST_DYNAMIC),
                                leak_address: '0};
                    n_state = S_IDLE;
                end else if (r_end) begin
                    n_valid = 1'b1;
                    n_res   = '{ok: 1'b1, status: ST_STATIC, leak_address: '0};
                    n_state = S_IDLE;
                end else begin
                    n_dv = 1'b1;
                    if (r_i == '0) begin
                        n_end = 1'b1;
                    end else begin
                        n_i = r_i - CW'(1);
                    end
                end
            end
            S_LOUT_RD: begin
                // wait for the outer entry, or pass once every entry is covered
                if (r_i == r_count) begin
                    n_valid = 1'b1;
                    n_res   = '{ok: 1'b1, status: ST_STATIC, leak_address: '0};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LOUT_CK;
                end
            end
            S_LOUT_CK: begin
                if (r_rd_a[SW]) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_LOUT_RD;
                end else if ((r_i + CW'(1)) == r_count) begin
                    // unfreed newest entry: nothing later can release it
                    n_valid = 1'b1;
                    n_res   = '{ok: 1'b0, status: ST_STATIC,
                                leak_address: ADDR_W'(r_rd_a[SW-1:0])};
                    n_state = S_IDLE;
                end else begin
                    n_j     = r_i + CW'(1);
                    n_dv    = 1'b0;
                    n_end   = 1'b0;
                    n_state = S_LIN;
                end
            end
            S_LIN: begin
                // look for a later release of the outer address
                if (l_hit) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_LOUT_RD;
                end else if (r_end) begin
                    n_valid = 1'b1;
                    n_res   = '{ok: 1'b0, status: ST_STATIC,
                                leak_address: ADDR_W'(r_rd_a[SW-1:0])};
                    n_state = S_IDLE;
                end else begin
                    n_dv = 1'b1;
                    if (r_j == (r_count - CW'(1))) begin
                        n_end = 1'b1;
                    end else begin
                        n_j = r_j + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // entry memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[IW-1:0]] <= wr_data;
        end
        r_rd_a <= mem[r_i[IW-1:0]];
        r_rd_b <= mem[r_j[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_dv    <= 1'b0;
            r_end   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_j     <= n_j;
            r_dv    <= n_dv;
            r_end   <= n_end;
            r_valid <= n_valid;
        end
    end

    // payload: hold the query key and the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qaddr <= in_addr;
        end
        r_res <= n_res;
    end

    `AELC_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(LOG_DEPTH), "log count over depth")
    `AELC_ASSERT_IMPL(a_state_onehot, 1'b1, $onehot(r_state), "state not one-hot")
    `AELC_ASSERT_IMPL(a_strobe_idle, o_valid, !busy, "result strobe while busy")
    `AELC_ASSERT_IMPL(a_scan_nonempty, busy, r_count != '0, "scan over an empty log")
    `AELC_ASSERT_NEXT(a_append_one, accept && (i_item.cmd == CMD_ALLOC || i_item.cmd == CMD_FREE), o_valid && !busy, "append took more than one cycle")

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the allocation event log checker core
`timescale 1ns / 1ps
module tb_top;
    import aelc_pkg::*;

    localparam int LOG_DEPTH   = 64;
    localparam int RUN_ITEMS   = 1750;
    // No idle bursts once this few items are left to send
    localparam int CALM_TAIL   = 150;
    // Watchdog limit, far above the length of a leak check over a full log
    localparam int STALL_LIMIT = 50000;
    localparam int DRAIN_WAIT  = 10;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    allocation_event_log_checker_core #(
        .LOG_DEPTH(LOG_DEPTH),
        .ADDR_BITS(ADDR_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Commands waiting to be sent, and results owed by the block, oldest first
    t_item   pending_items[$];
    t_result owed_results[$];

    // Shadow of the event log
    logic [ADDR_W-1:0] log_addr [LOG_DEPTH];
    logic              log_freed[LOG_DEPTH];
    int                log_used = 0;

    // Stimulus bookkeeping: addresses ever logged, allocations still open
    logic [ADDR_W-1:0] known_addrs[$];
    logic [ADDR_W-1:0] open_allocs[$];

    int   item_total   = 0;
    int   results_seen = 0;
    int   fail_count   = 0;
    int   idle_cycles  = 0;
    int   gap_left     = 0;
    bit   idle_on      = 1'b1;
    logic item_taken   = 1'b0;

    // Apply one command to the shadow log and return the result it must give
    function automatic t_result apply_log_command(t_item cmd_item);
        t_result r;
        bit      found;
        bit      released;
        int      k;
        int      j;
        r.ok           = 1'b1;
        r.status       = ST_STATIC;
        r.leak_address = '0;
        found          = 1'b0;
        case (cmd_item.cmd)
            CMD_ALLOC, CMD_FREE: begin
                // A full log refuses the append and keeps its contents
                if (log_used >= LOG_DEPTH) begin
                    r.ok = 1'b0;
                end else begin
                    log_addr[log_used]  = cmd_item.address;
                    log_freed[log_used] = (cmd_item.cmd == CMD_FREE);
                    log_used++;
                end
            end
            CMD_QUERY: begin
                // The newest matching entry decides the status
                for (k = log_used - 1; k >= 0 && !found; k--) begin
                    if (log_addr[k] == cmd_item.address) begin
                        r.status = log_freed[k] ? ST_FREED : ST_DYNAMIC;
                        found    = 1'b1;
                    end
                end
            end
            default: begin
                // Oldest unfreed entry with no later release of its address
                for (k = 0; k < log_used && !found; k++) begin
                    if (!log_freed[k]) begin
                        released = 1'b0;
                        for (j = k + 1; j < log_used; j++) begin
                            if (log_freed[j] && log_addr[j] == log_addr[k])
                                released = 1'b1;
                        end
                        if (!released) begin
                            r.ok           = 1'b0;
                            r.leak_address = log_addr[k];
                            found          = 1'b1;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic queue_command(t_cmd cmd, logic [ADDR_W-1:0] addr);
        t_item it;
        it.cmd     = cmd;
        it.address = addr;
        pending_items.push_back(it);
        if (cmd == CMD_ALLOC || cmd == CMD_FREE)
            known_addrs.push_back(addr);
        item_total++;
    endtask

    function automatic logic [ADDR_W-1:0] pick_known();
        return known_addrs[$urandom_range(0, known_addrs.size() - 1)];
    endfunction

    // Driver: offer items at the falling edge, hold each until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !item_taken) begin
            // hold: the block has not taken the transfer yet
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (pending_items.size() == 0) begin
            start <= 1'b0;
        end else if (idle_on && pending_items.size() > CALM_TAIL &&
                     $urandom_range(0, 5) == 0) begin
            // Idle burst that starts with this cycle; gap_left holds the rest of it
            gap_left = $urandom_range(0, 15);
            start <= 1'b0;
        end else begin
            // Now and then switch between idling and back-to-back stretches
            if ($urandom_range(0, 63) == 0)
                idle_on = !idle_on;
            i_item <= pending_items.pop_front();
            start  <= 1'b1;
        end
    end

    // Monitor: check results and predict accepted transfers at the rising edge
    always @(posedge i_clk) begin
        int      errs;
        t_result want;
        errs = 0;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= start && !busy;

            if (o_valid) begin
                if (owed_results.size() == 0) begin
                    $error("result with no command outstanding: ok=%0d status=%0d leak=%h",
                           o_result.ok, o_result.status, o_result.leak_address);
                    errs++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_result.ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, o_result.ok);
                        errs++;
                    end
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_result.status);
                        errs++;
                    end
                    if (o_result.leak_address !== want.leak_address) begin
                        $error("leak_address: expected %h, got %h",
                               want.leak_address, o_result.leak_address);
                        errs++;
                    end
                    results_seen <= results_seen + 1;
                end
            end

            // Predict after the check so a result is never matched to its own command
            if (start && !busy)
                owed_results.push_back(apply_log_command(i_item));

            if (errs != 0)
                fail_count <= fail_count + errs;

            // Watchdog: give up once nothing has moved for too long
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int                roll;
        int                sel;
        logic [ADDR_W-1:0] addr;

        // Directed opening: empty log, address extremes, reuse, stray release
        queue_command(CMD_QUERY, '0);             // never seen on an empty log
        queue_command(CMD_LEAK,  '0);             // empty log passes
        queue_command(CMD_ALLOC, '0);
        queue_command(CMD_ALLOC, '1);
        queue_command(CMD_QUERY, '1);             // still allocated
        queue_command(CMD_LEAK,  32'h1234_5678);  // leak at address zero reports zero
        queue_command(CMD_FREE,  '1);
        queue_command(CMD_FREE,  '0);
        queue_command(CMD_LEAK,  '1);             // everything released
        queue_command(CMD_QUERY, '0);             // freed
        queue_command(CMD_ALLOC, '0);             // reallocate a freed address
        queue_command(CMD_QUERY, '0);             // newest entry wins
        queue_command(CMD_QUERY, 32'h5555_AAAA);  // never seen
        queue_command(CMD_FREE,  32'hA5A5_5A5A);  // release with no allocation
        queue_command(CMD_QUERY, 32'hA5A5_5A5A);
        queue_command(CMD_LEAK,  '0);
        queue_command(CMD_ALLOC, 32'hAAAA_5555);
        queue_command(CMD_QUERY, 32'hAAAA_5555);

        // Random part: sparse appends so the log fills part way through the run,
        // then appends hit the full log; queries and leak checks throughout
        while (item_total < RUN_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                if (open_allocs.size() == 0 || $urandom_range(0, 1) == 0) begin
                    addr = ($urandom_range(0, 3) == 0) ? pick_known() : $urandom;
                    open_allocs.push_back(addr);
                    queue_command(CMD_ALLOC, addr);
                end else begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6) begin
                        addr = open_allocs.pop_front();
                    end else if (sel < 9) begin
                        sel  = $urandom_range(0, open_allocs.size() - 1);
                        addr = open_allocs[sel];
                        open_allocs.delete(sel);
                    end else begin
                        addr = $urandom;  // release of something never allocated
                    end
                    queue_command(CMD_FREE, addr);
                end
            end else if (roll < 21) begin
                queue_command(CMD_LEAK, $urandom);
            end else begin
                addr = ($urandom_range(0, 3) != 0) ? pick_known() : $urandom;
                queue_command(CMD_QUERY, addr);
            end
        end

        // Reset once, release it at a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every command gives exactly one result: wait for all of them
        while (results_seen < item_total)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (owed_results.size() != 0) begin
            $error("%0d results never arrived", owed_results.size());
            fail_count = fail_count + owed_results.size();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
